/* sv/tick_deadline_task_dispatcher_defines.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef TICK_DEADLINE_TASK_DISPATCHER_DEFINES_SVH
`define TICK_DEADLINE_TASK_DISPATCHER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdd assertion failed");

// Check that cons holds in the cycle after ante.
`define TDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdd assertion failed");

`endif

/* sv/tdd_pkg.sv */
// Types and constants of the tick deadline task dispatcher.
package tdd_pkg;

  localparam int OP_W       = 3;
  localparam int SLOT_W     = 3;
  localparam int DEADLINE_W = 32;

  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_START    = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd3;
  localparam logic [OP_W-1:0] OP_DONE     = 3'd4;

  localparam logic [DEADLINE_W-1:0] DEADLINE_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_t;

  // Command broadcast to every slot cell in the accept cycle.
  typedef struct packed {
    logic                  tick;
    logic                  start;
    logic                  stop;
    logic                  done;
    logic                  imm_ready;
    logic [SLOT_W-1:0]     slot;
    logic [DEADLINE_W-1:0] value;
  } cell_cmd_t;

endpackage

/* sv/tdd_ifs.sv */
// Valid/ready channel interfaces for the dispatcher's input and result words.
interface tdd_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdd_pkg::OP_W-1:0]       operation;
  logic [tdd_pkg::SLOT_W-1:0]     slot;
  logic [tdd_pkg::DEADLINE_W-1:0] period;

  modport source (output valid, operation, slot, period, input ready);
  modport sink   (input valid, operation, slot, period, output ready);
endinterface

interface tdd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      dispatched_valid;
  logic [tdd_pkg::SLOT_W-1:0] dispatched_slot;

  modport source (output valid, dispatched_valid, dispatched_slot, input ready);
  modport sink   (input valid, dispatched_valid, dispatched_slot, output ready);
endinterface

/* sv/tdd_cell.sv */
// One task slot: mode, deadline, ready flag and a dispatch scan token stage.
module tdd_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tdd_pkg::cell_cmd_t cmd,
  input  logic               tok_in,
  output logic               tok_out,
  output logic               tok,
  output logic               claim
);

  tdd_pkg::mode_t                  mode_r, mode_nxt;
  logic [tdd_pkg::DEADLINE_W-1:0]  deadline_r, deadline_nxt;
  logic                            ready_r, ready_nxt;
  logic                            tok_r;
  logic                            hit;

  // Slot indexes this cell cannot be addressed by never match.
  assign hit = (IDX < (1 << tdd_pkg::SLOT_W)) &&
               (cmd.slot == tdd_pkg::SLOT_W'(IDX));

  assign claim   = tok_r && ready_r && (mode_r == tdd_pkg::MODE_ARMED);
  assign tok_out = tok_r && !claim;
  assign tok     = tok_r;

  always_comb begin
    mode_nxt     = mode_r;
    deadline_nxt = deadline_r;
    ready_nxt    = ready_r;
    if (claim) begin
      mode_nxt  = tdd_pkg::MODE_RUNNING;
      ready_nxt = 1'b0;
    end else if (cmd.tick) begin
      if (mode_r == tdd_pkg::MODE_ARMED && deadline_r <= cmd.value) begin
        ready_nxt = 1'b1;
      end
    end else if (cmd.start && hit) begin
      mode_nxt     = tdd_pkg::MODE_ARMED;
      deadline_nxt = cmd.value;
      ready_nxt    = cmd.imm_ready;
    end else if (cmd.stop && hit) begin
      mode_nxt     = tdd_pkg::MODE_IDLE;
      deadline_nxt = tdd_pkg::DEADLINE_NONE;
      ready_nxt    = 1'b0;
    end else if (cmd.done && hit && mode_r == tdd_pkg::MODE_RUNNING) begin
      mode_nxt = tdd_pkg::MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= tdd_pkg::MODE_IDLE;
      deadline_r <= tdd_pkg::DEADLINE_NONE;
      ready_r    <= 1'b0;
      tok_r      <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      deadline_r <= deadline_nxt;
      ready_r    <= ready_nxt;
      tok_r      <= tok_in;
    end
  end

endmodule

/* sv/tick_deadline_task_dispatcher.sv */
// Top level of the tick deadline task dispatcher: slot cell chain and control.
// A row of NUM_SLOTS slot cells, each holding one task's mode, deadline and
// ready flag, plus a 32-bit tick count that only tick words advance. For a
// tick, start, stop or done word the command is broadcast to all cells and
// every cell updates in parallel at the accept edge, and a result word with
// dispatched_valid = 0 and dispatched_slot = 0 is loaded into the output
// register at the same edge. A dispatch word sends a scan token down the
// cell chain, one cell per cycle starting at slot 0; the first ready armed
// cell it meets claims it and the scan stops there. The dispatch result is
// registered when a cell claims the token, or with dispatched_valid = 0
// when the token reaches the last cell unclaimed. No word is accepted
// during a scan. The output register lets the next word be accepted in
// the same cycle that a result is taken. The tick-to-deadline compare is
// plain unsigned and ignores wrap; start deadlines are count + period
// modulo 2^32.
module tick_deadline_task_dispatcher #(
  parameter int NUM_SLOTS = 8
) (
  input logic       clk,
  input logic       rst_n,
  tdd_in_if.sink    in_chan,
  tdd_out_if.source out_chan
);

  `include "tick_deadline_task_dispatcher_defines.svh"

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [tdd_pkg::DEADLINE_W-1:0]  count_r, count_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic                            out_dv_r, out_dv_nxt;
  logic [tdd_pkg::SLOT_W-1:0]      out_slot_r, out_slot_nxt;

  logic                            accept;
  logic                            is_dispatch;
  logic                            scan_end;
  logic                            any_claim;
  tdd_pkg::cell_cmd_t              cmd;
  logic [NUM_SLOTS-1:0]            tok_out;
  logic [NUM_SLOTS-1:0]            tok_vec;
  logic [NUM_SLOTS-1:0]            claim_vec;

  // Accept only when idle and the output register is free or draining.
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_vld_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_dispatch   = (in_chan.operation == tdd_pkg::OP_DISPATCH);

  // Broadcast command; value is the new count on tick, the deadline on start.
  always_comb begin
    cmd           = '0;
    cmd.tick      = accept && (in_chan.operation == tdd_pkg::OP_TICK);
    cmd.start     = accept && (in_chan.operation == tdd_pkg::OP_START);
    cmd.stop      = accept && (in_chan.operation == tdd_pkg::OP_STOP);
    cmd.done      = accept && (in_chan.operation == tdd_pkg::OP_DONE);
    cmd.imm_ready = (in_chan.period == '0);
    cmd.slot      = in_chan.slot;
    cmd.value     = (in_chan.operation == tdd_pkg::OP_TICK)
                    ? count_r + tdd_pkg::DEADLINE_W'(1)
                    : count_r + in_chan.period;
  end

  // Cell chain: the scan token enters at slot 0 and walks upward.
  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      logic tok_in;
      if (gi == 0) begin : g_head
        assign tok_in = accept && is_dispatch;
      end else begin : g_link
        assign tok_in = tok_out[gi-1];
      end
      tdd_cell #(.IDX(gi)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .tok_in  (tok_in),
        .tok_out (tok_out[gi]),
        .tok     (tok_vec[gi]),
        .claim   (claim_vec[gi])
      );
    end
  endgenerate

  assign any_claim = |claim_vec;
  assign scan_end  = (state_r == ST_SCAN) &&
                     (any_claim || idx_r == IDX_W'(NUM_SLOTS - 1));

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    out_vld_nxt  = out_vld_r;
    out_dv_nxt   = out_dv_r;
    out_slot_nxt = out_slot_r;

    // Drop the held result once taken.
    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.tick) begin
            count_nxt = cmd.value;
          end
          if (is_dispatch) begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
          end else begin
            out_vld_nxt  = 1'b1;
            out_dv_nxt   = 1'b0;
            out_slot_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt    = ST_IDLE;
          out_vld_nxt  = 1'b1;
          out_dv_nxt   = any_claim;
          out_slot_nxt = any_claim ? tdd_pkg::SLOT_W'(idx_r) : '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dv_r   <= out_dv_nxt;
    out_slot_r <= out_slot_nxt;
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.dispatched_valid = out_dv_r;
  assign out_chan.dispatched_slot  = out_slot_r;

  // At most one token in the chain, and at most one claim.
  `TDD_ASSERT_NOW(a_tok_single, clk, rst_n, 1'b1, $onehot0(tok_vec))
  `TDD_ASSERT_NOW(a_claim_single, clk, rst_n, 1'b1, $onehot0(claim_vec))
  // A scan always holds the token at the cell the index points to.
  `TDD_ASSERT_NOW(a_scan_tok, clk, rst_n, state_r == ST_SCAN, tok_vec[idx_r])
  // An accepted dispatch starts a scan with the output register empty.
  `TDD_ASSERT_NEXT(a_disp_scan, clk, rst_n, accept && is_dispatch,
                   state_r == ST_SCAN && !out_vld_r)

endmodule
